FILE: sv/eess_pkg.sv
// Shared types and constants for the electrode scan sequencer.
`timescale 1ns / 1ps

package eess_pkg;

  localparam int PERIOD_W = 20;
  localparam int CFG_DATA_W = 20;
  localparam int GAIN_W = 2;
  localparam int NUM_CH = 4;
  localparam int TAG_W = 8;

  localparam logic [PERIOD_W-1:0] STATUS_PERIOD_RST = 20'd50000;
  localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST = 20'd5000;
  localparam logic [GAIN_W-1:0] ACTIVE_GAIN_RST = 2'd3;

  typedef enum logic [1:0] {
    CFG_STATUS_PERIOD = 2'd0,
    CFG_SCAN_PERIOD   = 2'd1,
    CFG_ACTIVE_GAIN   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [3:0] pair;
    logic [1:0] meas;
  } scan_idx_t;

  typedef struct packed {
    scan_idx_t                          idx;
    logic                               frame_end;
    logic [NUM_CH-1:0][GAIN_W-1:0]      gains;
    logic [NUM_CH-1:0][TAG_W-1:0]       tags;
  } scan_upd_t;

endpackage

FILE: sv/eit_electrode_scan_sequencer.sv
// Top level of the electrode scan sequencer.
//
// Input channel: one transfer per base-timer slot; in_tick high means a
// timer period has elapsed, low is an idle slot that still yields a result.
// Every input transfer yields exactly one result transfer on the out_
// channel, registered: the result is valid the cycle after the input
// transfer. One item per cycle is sustained; the only register between the
// channels is the output register, so the input stalls only while a result
// is held and out_stall is high.
// Two phase counters divide ticks by status_period and scan_period. On a
// scan strobe the result carries four tags from the indices before the
// advance, then the mux, source selects and gain codes after it.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 status
// period, 1 scan period, 2 active gain); write only while idle.
// Reset: counters and indices clear, gains off, registers take defaults
// (50000, 5000, 3), no result is pending.
`timescale 1ns / 1ps

module eit_electrode_scan_sequencer #(
  parameter int PHASE_WIDTH = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [eess_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_tick,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_status_toggle,
  output logic                            out_scan_step,
  output logic                            out_frame_end,
  output logic [7:0]                      out_tag_one,
  output logic [7:0]                      out_tag_two,
  output logic [7:0]                      out_tag_three,
  output logic [7:0]                      out_tag_four,
  output logic [1:0]                      out_meas_select,
  output logic [3:0]                      out_source_positive,
  output logic [3:0]                      out_source_negative,
  output logic [7:0]                      out_gain_one_to_four
);

  logic [eess_pkg::PERIOD_W-1:0] status_period_r;
  logic [eess_pkg::PERIOD_W-1:0] scan_period_r;
  logic [eess_pkg::GAIN_W-1:0]   active_gain_r;

  eess_pkg::scan_idx_t idx_r;
  eess_pkg::scan_idx_t idx_nxt;
  logic [7:0]          gain_r;
  logic [7:0]          gain_nxt;
  eess_pkg::scan_upd_t upd;

  logic in_xfer;
  logic adv;
  logic st;
  logic sc;
  logic out_valid_r;
  logic out_valid_nxt;

  logic       status_r;
  logic       scan_r;
  logic       frame_r;
  logic [7:0] tag_one_r;
  logic [7:0] tag_two_r;
  logic [7:0] tag_three_r;
  logic [7:0] tag_four_r;
  logic [1:0] meas_r;
  logic [3:0] src_pos_r;
  logic [3:0] src_neg_r;
  logic [7:0] gain_out_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign adv      = in_xfer && in_tick;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_period_r <= eess_pkg::STATUS_PERIOD_RST;
      scan_period_r   <= eess_pkg::SCAN_PERIOD_RST;
      active_gain_r   <= eess_pkg::ACTIVE_GAIN_RST;
    end else if (cfg_we) begin
      unique case (eess_pkg::cfg_reg_t'(cfg_index))
        eess_pkg::CFG_STATUS_PERIOD: status_period_r <= cfg_data;
        eess_pkg::CFG_SCAN_PERIOD:   scan_period_r   <= cfg_data;
        eess_pkg::CFG_ACTIVE_GAIN:   active_gain_r   <= cfg_data[eess_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  eess_phase_ctr #(.PHASE_WIDTH(PHASE_WIDTH)) u_status_ctr (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .period (status_period_r),
    .strobe (st)
  );

  eess_phase_ctr #(.PHASE_WIDTH(PHASE_WIDTH)) u_scan_ctr (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .period (scan_period_r),
    .strobe (sc)
  );

  eess_scan_step u_step (
    .idx         (idx_r),
    .active_gain (active_gain_r),
    .upd         (upd)
  );

  assign idx_nxt  = sc ? upd.idx : idx_r;
  assign gain_nxt = sc ? upd.gains : gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      gain_r <= '0;
    end else begin
      idx_r  <= idx_nxt;
      gain_r <= gain_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r    <= st;
      scan_r      <= sc;
      frame_r     <= sc && upd.frame_end;
      tag_one_r   <= sc ? upd.tags[0] : 8'd0;
      tag_two_r   <= sc ? upd.tags[1] : 8'd0;
      tag_three_r <= sc ? upd.tags[2] : 8'd0;
      tag_four_r  <= sc ? upd.tags[3] : 8'd0;
      meas_r      <= idx_nxt.meas;
      src_pos_r   <= idx_nxt.pair;
      src_neg_r   <= idx_nxt.pair + 4'd1;
      gain_out_r  <= gain_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status_toggle    = status_r;
  assign out_scan_step        = scan_r;
  assign out_frame_end        = frame_r;
  assign out_tag_one          = tag_one_r;
  assign out_tag_two          = tag_two_r;
  assign out_tag_three        = tag_three_r;
  assign out_tag_four         = tag_four_r;
  assign out_meas_select      = meas_r;
  assign out_source_positive  = src_pos_r;
  assign out_source_negative  = src_neg_r;
  assign out_gain_one_to_four = gain_out_r;

  a_frame_needs_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_frame_end |-> out_scan_step)
    else $error("frame end without scan step");

  a_tags_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_scan_step |-> (out_tag_one == 8'd0) && (out_tag_four == 8'd0))
    else $error("tags nonzero without scan step");

  a_source_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_source_negative == 4'(out_source_positive + 4'd1))
    else $error("source pair mismatch");

  a_scan_advances_meas: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && sc |=> idx_r.meas == 2'($past(idx_r.meas) + 2'd1))
    else $error("mux index did not advance on scan strobe");

endmodule

FILE: sv/eess_phase_ctr.sv
// Wrapping phase counter with strobe on reaching one.
`timescale 1ns / 1ps

module eess_phase_ctr #(
  parameter int PHASE_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [eess_pkg::PERIOD_W-1:0] period,
  output logic                          strobe
);

  localparam int CMP_W = (PHASE_WIDTH > eess_pkg::PERIOD_W) ? PHASE_WIDTH
                                                             : eess_pkg::PERIOD_W;

  logic [PHASE_WIDTH-1:0] phase_r;
  logic [PHASE_WIDTH-1:0] phase_nxt;
  logic [PHASE_WIDTH-1:0] inc;

  assign inc = phase_r + {{(PHASE_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    phase_nxt = phase_r;
    if (adv) begin
      if (CMP_W'(inc) >= CMP_W'(period)) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = inc;
      end
    end
  end

  assign strobe = adv && (phase_nxt == {{(PHASE_WIDTH-1){1'b0}}, 1'b1});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: sv/eess_scan_step.sv
// Mux advance, measurement tags and per-channel gain codes for one scan step.
`timescale 1ns / 1ps

module eess_scan_step (
  input  eess_pkg::scan_idx_t              idx,
  input  logic [eess_pkg::GAIN_W-1:0]      active_gain,
  output eess_pkg::scan_upd_t              upd
);

  logic [3:0] s;
  logic [3:0] s2;
  logic [1:0] meas_new;
  logic [3:0] pair_new;
  logic       meas_wrap;

  assign meas_new  = idx.meas + 2'd1;
  assign meas_wrap = (meas_new == 2'd0);
  assign pair_new  = meas_wrap ? (idx.pair + 4'd1) : idx.pair;
  assign s  = pair_new;
  assign s2 = pair_new + 4'd1;

  always_comb begin
    logic [3:0] e;
    logic [3:0] e2;
    upd.idx.meas  = meas_new;
    upd.idx.pair  = pair_new;
    upd.frame_end = meas_wrap && (pair_new == 4'd0);
    for (int a = 0; a < eess_pkg::NUM_CH; a++) begin
      upd.tags[a] = {idx.pair, 2'(a), idx.meas};
      e  = {2'(a), meas_new};
      e2 = e + 4'd1;
      upd.gains[a] = (e != s && e != s2 && e2 != s) ? active_gain : '0;
    end
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the electrode scan sequencer with its own cycle predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    logic                 status_toggle;
    logic                 scan_step;
    logic                 frame_end;
    logic [3:0][7:0]      tags;
    logic [1:0]           meas_select;
    logic [3:0]           src_pos;
    logic [3:0]           src_neg;
    logic [7:0]           gains;
  } scan_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [1:0]                      cfg_index = eess_pkg::CFG_STATUS_PERIOD;
  logic [eess_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_tick = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            out_status_toggle;
  logic                            out_scan_step;
  logic                            out_frame_end;
  logic [7:0]                      out_tag_one;
  logic [7:0]                      out_tag_two;
  logic [7:0]                      out_tag_three;
  logic [7:0]                      out_tag_four;
  logic [1:0]                      out_meas_select;
  logic [3:0]                      out_source_positive;
  logic [3:0]                      out_source_negative;
  logic [7:0]                      out_gain_one_to_four;

  eit_electrode_scan_sequencer u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_tick              (in_tick),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status_toggle    (out_status_toggle),
    .out_scan_step        (out_scan_step),
    .out_frame_end        (out_frame_end),
    .out_tag_one          (out_tag_one),
    .out_tag_two          (out_tag_two),
    .out_tag_three        (out_tag_three),
    .out_tag_four         (out_tag_four),
    .out_meas_select      (out_meas_select),
    .out_source_positive  (out_source_positive),
    .out_source_negative  (out_source_negative),
    .out_gain_one_to_four (out_gain_one_to_four)
  );

  always #6 clk = ~clk;

  // Register copies and sequencer state for prediction
  logic [eess_pkg::PERIOD_W-1:0] status_period_q = eess_pkg::STATUS_PERIOD_RST;
  logic [eess_pkg::PERIOD_W-1:0] scan_period_q = eess_pkg::SCAN_PERIOD_RST;
  logic [eess_pkg::GAIN_W-1:0]   active_gain_q = eess_pkg::ACTIVE_GAIN_RST;
  logic [eess_pkg::PERIOD_W-1:0] status_count = '0;
  logic [eess_pkg::PERIOD_W-1:0] scan_count = '0;
  logic [1:0]                    meas_idx = '0;
  logic [3:0]                    pair_idx = '0;
  logic [7:0]                    gain_word = '0;

  logic         tick_queue[$];
  scan_result_t expected_scans[$];

  int idle_level = 0;
  bit long_hold_req = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int scan_strobes = 0;
  int status_strobes = 0;
  int frames_seen = 0;
  scan_result_t want;

  function automatic logic [eess_pkg::PERIOD_W-1:0] next_phase(
      logic [eess_pkg::PERIOD_W-1:0] ph, logic [eess_pkg::PERIOD_W-1:0] per);
    logic [eess_pkg::PERIOD_W-1:0] n;
    n = ph + 1'b1;
    if (n >= per) n = '0;
    return n;
  endfunction

  function automatic logic [7:0] gains_for(logic [1:0] meas, logic [3:0] pair,
                                           logic [1:0] gain);
    logic [7:0] codes;
    logic [3:0] e;
    logic [3:0] e2;
    logic [3:0] s2;
    codes = '0;
    s2 = pair + 4'd1;
    for (int a = 0; a < eess_pkg::NUM_CH; a++) begin
      e = {a[1:0], meas};
      e2 = e + 4'd1;
      if (e != pair && e != s2 && e2 != pair) codes[2*a +: 2] = gain;
    end
    return codes;
  endfunction

  function automatic scan_result_t advance_sequencer(logic tick);
    scan_result_t r;
    r = '0;
    if (tick) begin
      status_count = next_phase(status_count, status_period_q);
      scan_count = next_phase(scan_count, scan_period_q);
      r.status_toggle = (status_count == 1);
      r.scan_step = (scan_count == 1);
      if (r.scan_step) begin
        for (int k = 0; k < eess_pkg::NUM_CH; k++) r.tags[k] = {pair_idx, k[1:0], meas_idx};
        meas_idx = meas_idx + 2'd1;
        if (meas_idx == 0) begin
          pair_idx = pair_idx + 4'd1;
          if (pair_idx == 0) r.frame_end = 1'b1;
        end
        gain_word = gains_for(meas_idx, pair_idx, active_gain_q);
      end
    end
    r.meas_select = meas_idx;
    r.src_pos = pair_idx;
    r.src_neg = pair_idx + 4'd1;
    r.gains = gain_word;
    return r;
  endfunction

  function automatic int draw_wait();
    case (idle_level)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 17)) : 0;
      default: return int'($urandom_range(0, 17));
    endcase
  endfunction

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (act_val !== exp_val) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, name, exp_val, act_val);
    end
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_scans.push_back(advance_sequencer(in_tick));
        if (in_tick) ticks_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_tick <= tick_queue.pop_front();
          gap_left = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_scans.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d arrived with none expected", results_seen);
        end else begin
          want = expected_scans.pop_front();
          check_field("status_toggle", 8'(want.status_toggle), 8'(out_status_toggle));
          check_field("scan_step", 8'(want.scan_step), 8'(out_scan_step));
          check_field("frame_end", 8'(want.frame_end), 8'(out_frame_end));
          check_field("tag_one", want.tags[0], out_tag_one);
          check_field("tag_two", want.tags[1], out_tag_two);
          check_field("tag_three", want.tags[2], out_tag_three);
          check_field("tag_four", want.tags[3], out_tag_four);
          check_field("meas_select", 8'(want.meas_select), 8'(out_meas_select));
          check_field("source_positive", 8'(want.src_pos), 8'(out_source_positive));
          check_field("source_negative", 8'(want.src_neg), 8'(out_source_negative));
          check_field("gain_one_to_four", want.gains, out_gain_one_to_four);
          if (want.scan_step) scan_strobes++;
          if (want.status_toggle) status_strobes++;
          if (want.frame_end) frames_seen++;
        end
        stall_left = draw_wait();
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on transfer activity
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(eess_pkg::cfg_reg_t idx, logic [eess_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      eess_pkg::CFG_STATUS_PERIOD: status_period_q = value;
      eess_pkg::CFG_SCAN_PERIOD:   scan_period_q = value;
      default:                     active_gain_q = value[eess_pkg::GAIN_W-1:0];
    endcase
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid || expected_scans.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_setting(logic [eess_pkg::PERIOD_W-1:0] st,
                               logic [eess_pkg::PERIOD_W-1:0] sc,
                               logic [eess_pkg::GAIN_W-1:0] g);
    write_reg(eess_pkg::CFG_STATUS_PERIOD, eess_pkg::CFG_DATA_W'(st));
    write_reg(eess_pkg::CFG_SCAN_PERIOD, eess_pkg::CFG_DATA_W'(sc));
    write_reg(eess_pkg::CFG_ACTIVE_GAIN, eess_pkg::CFG_DATA_W'(g));
  endtask

  initial begin
    logic [eess_pkg::PERIOD_W-1:0] st;
    logic [eess_pkg::PERIOD_W-1:0] sc;
    logic [eess_pkg::GAIN_W-1:0]   g;
    logic                          directed_ticks[$];

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Short directed run: joint strobes, idle slots, held state
    directed_ticks = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                       1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    apply_setting(20'd3, 20'd2, 2'd3);
    idle_level = 0;
    foreach (directed_ticks[i]) tick_queue.push_back(directed_ticks[i]);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin st = 20'd2; sc = 20'd2; g = 2'd0; end
        1: begin st = 20'hFFFFF; sc = 20'd3; g = 2'd1; end
        2: begin
          st = eess_pkg::PERIOD_W'($urandom_range(2, 40));
          sc = 20'hFFFFF;
          g = 2'd2;
        end
        3: begin
          st = eess_pkg::PERIOD_W'($urandom_range(2, 50));
          sc = eess_pkg::PERIOD_W'($urandom_range(20, 40));
          g = 2'd3;
        end
        default: begin
          st = eess_pkg::PERIOD_W'($urandom_range(2, 50));
          sc = eess_pkg::PERIOD_W'($urandom_range(2, 6));
          g = eess_pkg::GAIN_W'($urandom_range(0, 3));
        end
      endcase
      apply_setting(st, sc, g);
      idle_level = p % 3;
      for (int i = 0; i < 150; i++) tick_queue.push_back($urandom_range(0, 99) < 85);
      if (p == 3 || p == 6) long_hold_req = 1'b1;
      wait_drained();
    end

    $display("covered %0d results, %0d ticks, %0d scan steps, %0d status toggles",
             results_seen, ticks_sent, scan_strobes, status_strobes);
    $display("%0d frame ends over nine register settings incl. period and gain extremes",
             frames_seen);
    if (mismatches == 0 && expected_scans.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatches, expected_scans.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
